@@ design/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 5;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Broadcast to every cell for one item
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

@@ design/sorted_insert_priority_queue_core.sv @@
// Top level of the sorted priority queue built from a row of cells.
//
// Usage:
//   Input channel in_valid/in_ready carries one item: in_operation selects
//   insert (keep ascending order) or remove (take out the largest value),
//   in_value is the value to insert. Result channel out_valid/out_ready
//   carries one result item per input item: status, removed value, count,
//   empty/full flags, smallest and largest stored values after the item.
// Order: the cell row updates at the edge that accepts an item. A read-back
//   then loads the row (tail and freed slot) into the output register out_,
//   waiting while an earlier result still waits there unread.
// Flow: in_ready stays low from accept until that read-back, so the row
//   holds still and no new item is taken before the last is read back.
// Stall: a finished result waits in the output register while the next
//   item is accepted and applied; only its read-back waits for out_ready.
// Reset: rst_n (synchronous, active low) empties the queue and drops any
//   pending result. Stored values need no clearing.
module sorted_insert_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic signed [DATA_W-1:0]   in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_removed_value,
  output logic [COUNT_W-1:0]         out_count,
  output logic                       out_is_empty,
  output logic                       out_is_full,
  output logic signed [DATA_W-1:0]   out_smallest_value,
  output logic signed [DATA_W-1:0]   out_largest_value
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // occupancy, extended by a head marker below slot 0 and an empty slot above the top
  logic [CAPACITY:0]               occ_vec;
  logic signed [DATA_W-1:0]        val_vec [CAPACITY];
  logic                            occ_lo  [CAPACITY+1];

  logic [CNT_W-1:0]                count_r, count_nxt;
  logic                            busy_r, busy_nxt;
  status_t                         pend_status_r, pend_status_nxt;
  logic                            pend_rem_r, pend_rem_nxt;

  logic                            out_valid_r, out_valid_nxt;
  status_t                         out_status_r;
  logic signed [DATA_W-1:0]        out_removed_r, out_smallest_r, out_largest_r;
  logic [COUNT_W-1:0]              out_count_r;
  logic                            out_empty_r, out_full_r;

  logic                            accept;
  logic                            q_empty, q_full;
  logic                            load_out;
  cell_ctl_t                       ctl;
  logic signed [DATA_W-1:0]        tail_val, freed_val;
  logic [CNT_W+COUNT_W-1:0]        count_wide;

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign q_empty  = (count_r == '0);
  assign q_full   = (count_r == CNT_W'(CAPACITY));

  // broadcast the item to every cell in the accept cycle
  always_comb begin
    ctl.ins   = accept && (in_operation == OP_INSERT) && !q_full;
    ctl.rem   = accept && (in_operation == OP_REMOVE) && !q_empty;
    ctl.value = in_value;
  end

  // head marker: slot 0 sees an occupied left neighbour holding the new
  // value itself, so it never shifts in and takes the value when free
  assign occ_lo[0] = 1'b1;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [DATA_W-1:0] left_v;
      if (gi == 0) begin : g_head
        assign left_v = in_value;
      end else begin : g_body
        assign left_v = val_vec[gi-1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .left_occ  (occ_lo[gi]),
        .left_val  (left_v),
        .right_occ (occ_vec[gi+1]),
        .occ       (occ_vec[gi]),
        .val       (val_vec[gi])
      );
      assign occ_lo[gi+1] = occ_vec[gi];
    end
  endgenerate

  assign occ_vec[CAPACITY] = 1'b0;

  // read back the tail (last occupied slot) and the slot just freed
  always_comb begin
    tail_val  = '0;
    freed_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (occ_vec[i] && !occ_vec[i+1]) begin
        tail_val = tail_val | val_vec[i];
      end
      if (!occ_vec[i] && occ_lo[i]) begin
        freed_val = freed_val | val_vec[i];
      end
    end
  end

  // count and pending status, taken in the accept cycle
  always_comb begin
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    pend_rem_nxt    = pend_rem_r;
    busy_nxt        = busy_r;
    if (accept) begin
      busy_nxt     = 1'b1;
      pend_rem_nxt = ctl.rem;
      if (in_operation == OP_INSERT) begin
        pend_status_nxt = q_full ? ST_FULL : ST_DONE;
        if (!q_full) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        pend_status_nxt = q_empty ? ST_EMPTY : ST_DONE;
        if (!q_empty) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
    end else if (load_out) begin
      busy_nxt = 1'b0;
    end
  end

  // hold the finished result until taken, advance the next one when free
  assign load_out = busy_r && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_rem_r    <= pend_rem_nxt;
  end

  // report count masked to the field width
  assign count_wide = {{COUNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r   <= pend_status_r;
      out_removed_r  <= pend_rem_r ? freed_val : '0;
      out_count_r    <= count_wide[COUNT_W-1:0];
      out_empty_r    <= q_empty;
      out_full_r     <= q_full;
      out_smallest_r <= occ_vec[0] ? val_vec[0] : '0;
      out_largest_r  <= tail_val;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_removed_value  = out_removed_r;
  assign out_count          = out_count_r;
  assign out_is_empty       = out_empty_r;
  assign out_is_full        = out_full_r;
  assign out_smallest_value = out_smallest_r;
  assign out_largest_value  = out_largest_r;

`ifndef SYNTHESIS
  a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_vec) == int'(count_r))
    else $error("count differs from occupied cells");

  a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("occupied cells not packed from slot 0");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && !in_ready))
    else $error("item accepted without read-back cycle");
`endif

endmodule

@@ design/spq_cell.sv @@
// One slot of the sorted cell row: holds a value and its occupancy bit.
module spq_cell
  import spq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctl_t                ctl,
  input  logic                     left_occ,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic                     right_occ,
  output logic                     occ,
  output logic signed [DATA_W-1:0] val
);

  logic                     occ_r, occ_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     shift_in;
  logic                     below;

  assign shift_in = left_occ && (ctl.value < left_val);
  assign below    = ctl.value < val_r;

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (ctl.ins) begin
      if (occ_r) begin
        if (shift_in) begin
          val_nxt = left_val;
        end else if (below) begin
          val_nxt = ctl.value;
        end
      end else if (left_occ) begin
        // first free slot: take the neighbour's value or the new one
        occ_nxt = 1'b1;
        val_nxt = shift_in ? left_val : ctl.value;
      end
    end else if (ctl.rem) begin
      // drop occupancy at the tail only
      occ_nxt = occ_r & right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign occ = occ_r;
  assign val = val_r;

endmodule
